// ===== sv/pipelined_prime_sieve_assert.svh =====
// assertion macros for the pipelined prime sieve
// no dependencies; included by the top level
`ifndef PIPELINED_PRIME_SIEVE_ASSERT_SVH
`define PIPELINED_PRIME_SIEVE_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

// ===== sv/pps_pkg.sv =====
// shared constants and cell control type for the pipelined prime sieve
// no dependencies
`timescale 1ns / 1ps

package pps_pkg;

    localparam int CELL_COUNT_DEF = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int CAND_BITS      = 16;

    typedef struct packed {
        logic load;
        logic step;
        logic din_bit;
        logic x_zero;
        logic ripple;
        logic store;
    } cell_ctrl_t;

endpackage

// ===== sv/pipelined_prime_sieve.sv =====
// top level: sequencer, output register and the chain of filter cells
// one word at a time: accept, VALUE_BITS remainder steps in every cell at once,
// the hit flag rippling down the cell chain, then a decision that drops a word with
// a hit and otherwise waits for the output register to be free
// reset (aresetn low, synchronous) empties the chain and drops any pending result
`timescale 1ns / 1ps

module pipelined_prime_sieve #(
    parameter int CELL_COUNT = pps_pkg::CELL_COUNT_DEF,
    parameter int VALUE_BITS = pps_pkg::VALUE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pps_pkg::CAND_BITS-1:0]  s_candidate,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pps_pkg::CAND_BITS-1:0]  m_prime_value,
    output logic                           m_table_full
);

    localparam int CNT_BITS = $clog2(CELL_COUNT + 1);
    localparam int MAX_CNT  = (VALUE_BITS > CELL_COUNT) ? VALUE_BITS : CELL_COUNT;
    localparam int CW       = (MAX_CNT > 1) ? $clog2(MAX_CNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RIP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]  x_reg, x_next;
    logic [VALUE_BITS-1:0]  sh_reg, sh_next;
    logic [CNT_BITS-1:0]    cells_used_reg, cells_used_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]  out_prime_reg, out_prime_next;
    logic                   out_full_reg, out_full_next;

    logic [VALUE_BITS+pps_pkg::CAND_BITS-1:0] cand_ext;
    logic [VALUE_BITS+pps_pkg::CAND_BITS-1:0] out_ext;
    logic [VALUE_BITS-1:0]  x_in;
    logic                   in_accept;
    logic                   out_free;
    logic                   full;
    logic                   hit;
    logic                   load_out;
    logic                   store_en;
    logic [CELL_COUNT:0]    hit_chain;
    pps_pkg::cell_ctrl_t    ctrl;

    assign cand_ext  = {{VALUE_BITS{1'b0}}, s_candidate};
    assign x_in      = cand_ext[VALUE_BITS-1:0];
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid & s_ready;
    assign out_free  = ~out_valid_reg | m_ready;
    assign full      = (cells_used_reg == CNT_BITS'(CELL_COUNT));
    assign hit       = hit_chain[CELL_COUNT];
    assign load_out  = (state_reg == ST_DONE) & ~hit & out_free;
    assign store_en  = load_out & ~full;

    assign ctrl.load    = in_accept;
    assign ctrl.step    = (state_reg == ST_DIV);
    assign ctrl.din_bit = sh_reg[VALUE_BITS-1];
    assign ctrl.x_zero  = (x_reg == '0);
    assign ctrl.ripple  = (state_reg == ST_RIP);
    assign ctrl.store   = store_en;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        pps_cell #(
            .IDX        (i),
            .VALUE_BITS (VALUE_BITS),
            .CNT_BITS   (CNT_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .x          (x_reg),
            .cells_used (cells_used_reg),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1])
        );
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        x_next          = x_reg;
        sh_next         = sh_reg;
        cells_used_next = cells_used_reg;
        out_valid_next  = out_valid_reg;
        out_prime_next  = out_prime_reg;
        out_full_next   = out_full_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    x_next     = x_in;
                    sh_next    = x_in;
                    cnt_next   = CW'(VALUE_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                sh_next = {sh_reg[VALUE_BITS-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    cnt_next   = CW'(CELL_COUNT - 1);
                    state_next = ST_RIP;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_RIP: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (hit) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_prime_next = x_reg;
                    out_full_next  = full;
                    if (!full) begin
                        cells_used_next = cells_used_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cells_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cells_used_reg <= cells_used_next;
            out_valid_reg  <= out_valid_next;
        end
        cnt_reg       <= cnt_next;
        x_reg         <= x_next;
        sh_reg        <= sh_next;
        out_prime_reg <= out_prime_next;
        out_full_reg  <= out_full_next;
    end

    assign out_ext       = {{pps_pkg::CAND_BITS{1'b0}}, out_prime_reg};
    assign m_valid       = out_valid_reg;
    assign m_prime_value = out_ext[pps_pkg::CAND_BITS-1:0];
    assign m_table_full  = out_full_reg;

    `include "pipelined_prime_sieve_assert.svh"

    `PPS_ASSERT_IMP(a_full_flag_count, aclk, aresetn, m_valid && m_table_full, full)
    `PPS_ASSERT_NXT(a_store_counts, aclk, aresetn, store_en,
        cells_used_reg == $past(cells_used_reg) + 1'b1)
    `PPS_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, in_accept, !s_ready)

endmodule

// ===== sv/pps_cell.sv =====
// one filter cell: stored prime, bit-serial remainder, hit chain stage
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_cell #(
    parameter int IDX        = 0,
    parameter int VALUE_BITS = pps_pkg::VALUE_BITS_DEF,
    parameter int CNT_BITS   = 5
) (
    input  logic                   aclk,
    input  pps_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]  x,
    input  logic [CNT_BITS-1:0]    cells_used,
    input  logic                   hit_in,
    output logic                   hit_out
);

    localparam logic [CNT_BITS-1:0] IDX_C = CNT_BITS'(IDX);

    logic [VALUE_BITS-1:0] prime_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [VALUE_BITS:0]   rem_shift;
    logic [VALUE_BITS:0]   rem_diff;
    logic                  rem_ge;
    logic                  used;
    logic                  own_hit;

    assign rem_shift = {rem_reg, ctrl.din_bit};
    assign rem_diff  = rem_shift - {1'b0, prime_reg};
    assign rem_ge    = rem_shift >= {1'b0, prime_reg};
    assign used      = IDX_C < cells_used;
    assign own_hit   = used & ((prime_reg == '0) ? ctrl.x_zero : (rem_reg == '0));

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.load) begin
            rem_next = '0;
        end else if (ctrl.step) begin
            rem_next = rem_ge ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
        end
    end

    always_comb begin
        hit_next = hit_reg;
        if (ctrl.ripple) begin
            hit_next = hit_in | own_hit;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        hit_reg <= hit_next;
        if (ctrl.store && (cells_used == IDX_C)) begin
            prime_reg <= x;
        end
    end

    assign hit_out = hit_reg;

endmodule
